/* rtl/core/assert_macros.svh */
// Assertion macros used by the predictor back end.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* rtl/core/tage_pkg.sv */
// Types and constants for the two-table TAGE predictor.
// Depends on nothing.
package tage_pkg;
  localparam int ADDR_W = 48;
  localparam int TAG_W = 16;
  localparam int CTR_W = 3;
  localparam int U_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;
  localparam logic [1:0] SRC_BASE = 2'd0;
  localparam logic [1:0] SRC_SHORT = 2'd1;
  localparam logic [1:0] SRC_LONG = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_pc;
    logic taken;
  } branch_in_t;

  typedef struct packed {
    logic predicted_taken;
    logic correct;
    logic [1:0] provider_source;
  } branch_out_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic signed [CTR_W-1:0] ctr;
    logic [U_W-1:0] u;
  } tag_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WRITE, ST_AGE
  } back_state_t;
endpackage

/* rtl/core/tage_front.sv */
// Front end: window check and queueing of accepted branches.
// Depends on tage_pkg.
module tage_front #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  tage_pkg::branch_in_t in_item,
  input  logic [tage_pkg::ADDR_W-1:0] range_low,
  input  logic [tage_pkg::ADDR_W-1:0] range_high,
  input  logic pop,
  output logic q_valid,
  output tage_pkg::branch_in_t q_item,
  output logic full
);
  localparam int PW = $clog2(DEPTH);
  tage_pkg::branch_in_t fifo [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;
  logic push, inwin;

  assign inwin = (in_item.branch_pc >= range_low) && (in_item.branch_pc <= range_high);
  assign full = (cnt == (PW+1)'(DEPTH));
  assign push = start && !full && inwin;
  assign q_valid = (cnt != '0);
  assign q_item = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

/* rtl/core/tage_back.sv */
// Back end: table clearing, lookup, prediction, update and ageing.
// Depends on tage_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tage_back #(
  parameter int SHORT_ENTRIES = 512,
  parameter int LONG_ENTRIES = 512,
  parameter int SHORT_HIST = 8,
  parameter int LONG_HIST = 16,
  parameter int BASE_ENTRIES = 4096,
  parameter int AGING_PERIOD = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  tage_pkg::branch_in_t q_item,
  output logic pop,
  output logic done,
  output logic res_valid,
  output tage_pkg::branch_out_t res
);
  localparam int SW = $clog2(SHORT_ENTRIES);
  localparam int LW = $clog2(LONG_ENTRIES);
  localparam int BW = $clog2(BASE_ENTRIES);
  localparam int CW = (SW > LW) ? ((SW > BW) ? SW : BW) : ((LW > BW) ? LW : BW);
  localparam int AW = $clog2(AGING_PERIOD);
  localparam int HW = 64;

  tage_pkg::tag_entry_t st [SHORT_ENTRIES];
  tage_pkg::tag_entry_t lt [LONG_ENTRIES];
  logic [1:0] bt [BASE_ENTRIES];

  tage_pkg::back_state_t state, state_next;
  logic [CW:0] sweep;
  logic [LONG_HIST-1:0] hist;
  logic [AW-1:0] age;
  tage_pkg::branch_in_t cur;
  logic [SW-1:0] i1;
  logic [LW-1:0] i2;
  logic [BW-1:0] bi;
  logic [tage_pkg::TAG_W-1:0] t1, t2;
  tage_pkg::tag_entry_t e1, e2, e1_new, e2_new;
  tage_pkg::tag_entry_t a1, a2;
  logic [1:0] be, be_new;
  logic [tage_pkg::TAG_W-1:0] t1_c, t2_c;
  logic [SW-1:0] i1_c;
  logic [LW-1:0] i2_c;
  logic [HW-1:0] hs, hl, hxs, hxl, pc64, mixs, mixl;
  logic hit1, hit2, bpred, apred, pred, act, mis, clr_done, aging;
  logic [1:0] src;

  assign pc64 = HW'(q_item.branch_pc);
  assign hs = HW'(hist) & ((HW'(1) << SHORT_HIST) - HW'(1));
  assign hl = (LONG_HIST >= HW) ? HW'(hist) : HW'(hist) & ((HW'(1) << LONG_HIST) - HW'(1));
  assign hxs = hs ^ (hs >> 3) ^ (hs << 5);
  assign hxl = hl ^ (hl >> 3) ^ (hl << 5);
  assign mixs = (pc64 ^ hxs ^ (pc64 >> 2)) & HW'(SHORT_ENTRIES - 1);
  assign mixl = (pc64 ^ hxl ^ (pc64 >> 2)) & HW'(LONG_ENTRIES - 1);
  assign i1_c = SW'(mixs);
  assign i2_c = LW'(mixl);
  assign t1_c = tage_pkg::TAG_W'(pc64 ^ (hs >> 2) ^ (hs << 1));
  assign t2_c = tage_pkg::TAG_W'(pc64 ^ (hl >> 2) ^ (hl << 1));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
      i1 <= i1_c;
      i2 <= i2_c;
      t1 <= t1_c;
      t2 <= t2_c;
      bi <= BW'(q_item.branch_pc % tage_pkg::ADDR_W'(BASE_ENTRIES));
      e1 <= st[i1_c];
      e2 <= lt[i2_c];
      be <= bt[BW'(q_item.branch_pc % tage_pkg::ADDR_W'(BASE_ENTRIES))];
    end
  end

  always_ff @(posedge clk) begin
    a1 <= st[SW'(sweep)];
    a2 <= lt[LW'(sweep)];
  end

  assign act = cur.taken;
  assign hit1 = (e1.tag == t1);
  assign hit2 = (e2.tag == t2);
  assign bpred = be[1];
  assign apred = hit1 ? !e1.ctr[2] : bpred;
  assign src = hit2 ? tage_pkg::SRC_LONG : (hit1 ? tage_pkg::SRC_SHORT : tage_pkg::SRC_BASE);
  always_comb begin
    if (hit2) pred = (e2.u == '0) ? apred : !e2.ctr[2];
    else if (hit1) pred = (e1.u == '0) ? apred : !e1.ctr[2];
    else pred = bpred;
  end
  assign mis = (pred != act);

  always_comb begin
    be_new = be;
    if (act && be != 2'd3) be_new = be + 2'd1;
    if (!act && be != 2'd0) be_new = be - 2'd1;
    e1_new = e1;
    e2_new = e2;
    if (hit2) begin
      if (act && e2.ctr != 3'sd3) e2_new.ctr = e2.ctr + 3'sd1;
      if (!act && e2.ctr != -3'sd2) e2_new.ctr = e2.ctr - 3'sd1;
      if (!mis && e2.u != 2'd3) e2_new.u = e2.u + 2'd1;
      if (mis && e2.u != 2'd0) e2_new.u = e2.u - 2'd1;
    end else if (hit1) begin
      if (act && e1.ctr != 3'sd3) e1_new.ctr = e1.ctr + 3'sd1;
      if (!act && e1.ctr != -3'sd2) e1_new.ctr = e1.ctr - 3'sd1;
      if (!mis && e1.u != 2'd3) e1_new.u = e1.u + 2'd1;
      if (mis && e1.u != 2'd0) e1_new.u = e1.u - 2'd1;
    end
    if (mis) begin
      if (!hit2 && e2.u == '0) begin
        e2_new.tag = t2;
        e2_new.ctr = act ? 3'sd0 : -3'sd1;
        e2_new.u = '0;
      end else if (!hit1 && e1.u == '0) begin
        e1_new.tag = t1;
        e1_new.ctr = act ? 3'sd0 : -3'sd1;
        e1_new.u = '0;
      end
    end
  end

  assign clr_done = (sweep == (CW+1)'(BASE_ENTRIES - 1)) &&
                    (sweep >= (CW+1)'(SHORT_ENTRIES - 1)) &&
                    (sweep >= (CW+1)'(LONG_ENTRIES - 1));
  assign aging = (age == AW'(AGING_PERIOD - 1));

  // ageing writes back the entry read on the previous sweep step
  always_ff @(posedge clk) begin
    if (state == tage_pkg::ST_CLEAR) begin
      if (sweep < (CW+1)'(SHORT_ENTRIES)) st[SW'(sweep)] <= '0;
      if (sweep < (CW+1)'(LONG_ENTRIES)) lt[LW'(sweep)] <= '0;
      if (sweep < (CW+1)'(BASE_ENTRIES)) bt[BW'(sweep)] <= 2'd2;
    end else if (state == tage_pkg::ST_WRITE) begin
      st[i1] <= e1_new;
      lt[i2] <= e2_new;
      bt[bi] <= be_new;
    end else if (state == tage_pkg::ST_AGE) begin
      if (sweep != '0 && sweep <= (CW+1)'(SHORT_ENTRIES))
        st[SW'(sweep - 1'b1)] <= '{tag: a1.tag, ctr: a1.ctr, u: a1.u >> 1};
      if (sweep != '0 && sweep <= (CW+1)'(LONG_ENTRIES))
        lt[LW'(sweep - 1'b1)] <= '{tag: a2.tag, ctr: a2.ctr, u: a2.u >> 1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tage_pkg::ST_CLEAR;
      sweep <= '0;
      hist <= '0;
      age <= '0;
    end else begin
      state <= state_next;
      if (state == tage_pkg::ST_CLEAR || state == tage_pkg::ST_AGE) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (state == tage_pkg::ST_WRITE) begin
        hist <= {hist[LONG_HIST-2:0], act};
        age <= aging ? '0 : age + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    res_valid = 1'b0;
    res = '{predicted_taken: pred, correct: !mis, provider_source: src};
    unique case (state)
      tage_pkg::ST_CLEAR: if (clr_done || sweep >= (CW+1)'(BASE_ENTRIES - 1) &&
                              sweep >= (CW+1)'(SHORT_ENTRIES - 1) &&
                              sweep >= (CW+1)'(LONG_ENTRIES - 1))
                            state_next = tage_pkg::ST_IDLE;
      tage_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          state_next = tage_pkg::ST_WRITE;
        end
      end
      tage_pkg::ST_WRITE: begin
        res_valid = 1'b1;
        state_next = aging ? tage_pkg::ST_AGE : tage_pkg::ST_IDLE;
      end
      tage_pkg::ST_READ: state_next = tage_pkg::ST_WRITE;
      tage_pkg::ST_AGE: if (sweep >= (CW+1)'(SHORT_ENTRIES) &&
                            sweep >= (CW+1)'(LONG_ENTRIES))
                          state_next = tage_pkg::ST_IDLE;
      default: state_next = tage_pkg::ST_IDLE;
    endcase
  end

  assign done = (state != tage_pkg::ST_CLEAR);

  `CHK_IMPL(a_pop_needs_item, clk, rst, pop, q_valid)
  `CHK_NEXT(a_pop_then_result, clk, rst, pop, res_valid)
  `CHK_IMPL(a_result_src_valid, clk, rst, res_valid, res.provider_source != 2'd3)
  `CHK_IMPL(a_no_pop_clearing, clk, rst, state == tage_pkg::ST_CLEAR, !pop)
endmodule

/* rtl/core/tage_branch_predictor_two_table.sv */
// Two-table TAGE branch predictor: one result per in-window branch.
// An accepted branch is queued in the front FIFO, popped by the back end, and its result strobe comes in ST_WRITE.
// The back end takes one branch at a time: lookup on pop, then write-back of the same entries in ST_WRITE.
// Every AGING_PERIOD branches a sweep halves the usefulness counters of both tagged tables.
// After rst a clearing pass over all three tables runs; busy is high.
module tage_branch_predictor_two_table #(
  parameter int SHORT_ENTRIES = 512,
  parameter int LONG_ENTRIES = 512,
  parameter int SHORT_HIST = 8,
  parameter int LONG_HIST = 16,
  parameter int BASE_ENTRIES = 4096,
  parameter int AGING_PERIOD = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  tage_pkg::branch_in_t in_data,
  output logic result_valid,
  output tage_pkg::branch_out_t result,
  input  logic cfg_we,
  input  logic [tage_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tage_pkg::ADDR_W-1:0] cfg_data
);
  logic [tage_pkg::ADDR_W-1:0] range_low, range_high;
  logic q_valid, pop, full, ready;
  tage_pkg::branch_in_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= '0;
      range_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tage_pkg::REG_RANGE_LOW: range_low <= cfg_data;
        tage_pkg::REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = full || !ready;

  tage_front #(.DEPTH(2)) u_front (
    .clk, .rst, .start(start && ready), .in_item(in_data), .range_low, .range_high,
    .pop, .q_valid, .q_item, .full
  );

  tage_back #(
    .SHORT_ENTRIES(SHORT_ENTRIES), .LONG_ENTRIES(LONG_ENTRIES),
    .SHORT_HIST(SHORT_HIST), .LONG_HIST(LONG_HIST),
    .BASE_ENTRIES(BASE_ENTRIES), .AGING_PERIOD(AGING_PERIOD)
  ) u_back (
    .clk, .rst, .q_valid, .q_item, .pop, .done(ready),
    .res_valid(result_valid), .res(result)
  );
endmodule

/* verif/tb_tage_branch_predictor_two_table.sv */
// Self-checking testbench for the two-table TAGE branch predictor.
// Depends on tage_pkg and tage_branch_predictor_two_table; holds its own predictor of the block.
module tb_tage_branch_predictor_two_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SHORT = 512;
  localparam int N_LONG = 512;
  localparam int H_SHORT = 8;
  localparam int H_LONG = 16;
  localparam int N_BASE = 4096;
  localparam int AGE_PERIOD = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam logic [tage_pkg::ADDR_W-1:0] PC_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tage_pkg::branch_in_t in_data = '0;
  logic result_valid;
  tage_pkg::branch_out_t result;
  logic cfg_we = 1'b0;
  logic [tage_pkg::CFG_IDX_W-1:0] cfg_index = tage_pkg::REG_RANGE_LOW;
  logic [tage_pkg::ADDR_W-1:0] cfg_data = '0;

  tage_branch_predictor_two_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [tage_pkg::TAG_W-1:0] short_tag [N_SHORT];
  int short_ctr [N_SHORT];
  int short_u [N_SHORT];
  logic [tage_pkg::TAG_W-1:0] long_tag [N_LONG];
  int long_ctr [N_LONG];
  int long_u [N_LONG];
  int base_ctr [N_BASE];
  logic [H_LONG-1:0] path_hist;
  int age_count;
  logic [tage_pkg::ADDR_W-1:0] win_low, win_high;

  tage_pkg::branch_out_t pending_predictions[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  function automatic longint unsigned hist_bits(int hlen);
    return longint'(path_hist) & ((64'd1 << hlen) - 64'd1);
  endfunction

  function automatic int table_index(longint unsigned pc, int hlen, int entries);
    longint unsigned h;
    h = hist_bits(hlen);
    h = h ^ (h >> 3) ^ (h << 5);
    return int'(((pc ^ h ^ (pc >> 2)) & longint'(entries - 1)) % entries);
  endfunction

  function automatic logic [tage_pkg::TAG_W-1:0] table_tag(longint unsigned pc, int hlen);
    longint unsigned h;
    h = hist_bits(hlen);
    return tage_pkg::TAG_W'(pc ^ (h >> 2) ^ (h << 1));
  endfunction

  task automatic reset_predictor();
    for (int k = 0; k < N_SHORT; k++) begin
      short_tag[k] = '0; short_ctr[k] = 0; short_u[k] = 0;
    end
    for (int k = 0; k < N_LONG; k++) begin
      long_tag[k] = '0; long_ctr[k] = 0; long_u[k] = 0;
    end
    for (int k = 0; k < N_BASE; k++) base_ctr[k] = 2;
    path_hist = '0;
    age_count = 0;
    win_low = '0;
    win_high = '0;
  endtask

  task automatic predict_branch(tage_pkg::branch_in_t br);
    longint unsigned pc;
    int si, li, bi;
    logic [tage_pkg::TAG_W-1:0] st, lt;
    bit hit_s, hit_l, base_p, alt_p, pred, act;
    tage_pkg::branch_out_t exp;
    pc = longint'(br.branch_pc);
    act = br.taken;
    if (br.branch_pc < win_low || br.branch_pc > win_high) return;
    si = table_index(pc, H_SHORT, N_SHORT);
    li = table_index(pc, H_LONG, N_LONG);
    st = table_tag(pc, H_SHORT);
    lt = table_tag(pc, H_LONG);
    hit_s = short_tag[si] == st;
    hit_l = long_tag[li] == lt;
    bi = int'(pc % N_BASE);
    base_p = base_ctr[bi] >= 2;
    alt_p = hit_s ? (short_ctr[si] >= 0) : base_p;
    if (hit_l) begin
      pred = (long_u[li] == 0) ? alt_p : (long_ctr[li] >= 0);
      exp.provider_source = tage_pkg::SRC_LONG;
    end else if (hit_s) begin
      pred = (short_u[si] == 0) ? alt_p : (short_ctr[si] >= 0);
      exp.provider_source = tage_pkg::SRC_SHORT;
    end else begin
      pred = base_p;
      exp.provider_source = tage_pkg::SRC_BASE;
    end
    exp.predicted_taken = pred;
    exp.correct = pred == act;
    pending_predictions = {pending_predictions, exp};

    if (act && base_ctr[bi] < 3) base_ctr[bi]++;
    if (!act && base_ctr[bi] > 0) base_ctr[bi]--;
    if (hit_l) begin
      if (act && long_ctr[li] < 3) long_ctr[li]++;
      if (!act && long_ctr[li] > -2) long_ctr[li]--;
      if (pred == act && long_u[li] < 3) long_u[li]++;
      if (pred != act && long_u[li] > 0) long_u[li]--;
    end else if (hit_s) begin
      if (act && short_ctr[si] < 3) short_ctr[si]++;
      if (!act && short_ctr[si] > -2) short_ctr[si]--;
      if (pred == act && short_u[si] < 3) short_u[si]++;
      if (pred != act && short_u[si] > 0) short_u[si]--;
    end
    if (pred != act) begin
      if (!hit_l && long_u[li] == 0) begin
        long_tag[li] = lt; long_ctr[li] = act ? 0 : -1; long_u[li] = 0;
      end else if (!hit_s && short_u[si] == 0) begin
        short_tag[si] = st; short_ctr[si] = act ? 0 : -1; short_u[si] = 0;
      end
    end
    path_hist = {path_hist[H_LONG-2:0], act};
    age_count++;
    if (age_count >= AGE_PERIOD) begin
      age_count = 0;
      for (int k = 0; k < N_SHORT; k++) short_u[k] = short_u[k] >> 1;
      for (int k = 0; k < N_LONG; k++) long_u[k] = long_u[k] >> 1;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_predictions.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        tage_pkg::branch_out_t exp;
        exp = pending_predictions.pop_front();
        if (result.predicted_taken !== exp.predicted_taken)
          report_mismatch($sformatf("predicted_taken %b, want %b",
                                    result.predicted_taken, exp.predicted_taken));
        if (result.correct !== exp.correct)
          report_mismatch($sformatf("correct %b, want %b", result.correct, exp.correct));
        if (result.provider_source !== exp.provider_source)
          report_mismatch($sformatf("provider_source %0d, want %0d",
                                    result.provider_source, exp.provider_source));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_branch(logic [tage_pkg::ADDR_W-1:0] pc, bit tk);
    int gap;
    start <= 1'b1;
    in_data <= '{branch_pc: pc, taken: tk};
    do @(posedge clk); while (busy);
    predict_branch('{branch_pc: pc, taken: tk});
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_predictions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_window(logic [tage_pkg::ADDR_W-1:0] lo,
                              logic [tage_pkg::ADDR_W-1:0] hi);
    drain_and_settle();
    cfg_we <= 1'b1; cfg_index <= tage_pkg::REG_RANGE_LOW; cfg_data <= lo;
    @(posedge clk);
    cfg_index <= tage_pkg::REG_RANGE_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_low = lo;
    win_high = hi;
    @(posedge clk);
  endtask

  task automatic test_reset_window();
    send_branch('0, 1'b1);
    send_branch('0, 1'b0);
    send_branch('0, 1'b0);
    send_branch(48'd1, 1'b1);
    send_branch(PC_MAX, 1'b0);
    send_branch('0, 1'b1);
  endtask

  task automatic test_full_window_extremes();
    write_window('0, PC_MAX);
    send_branch(PC_MAX, 1'b1);
    send_branch(PC_MAX, 1'b0);
    send_branch('0, 1'b0);
    send_branch(48'h5555_5555_5555, 1'b1);
    send_branch(48'hAAAA_AAAA_AAAA, 1'b0);
    send_branch(48'h0000_0000_FFFF, 1'b1);
    send_branch(48'hFFFF_FFFF_0000, 1'b0);
    send_branch(48'h8000_0000_0000, 1'b1);
  endtask

  task automatic test_empty_window();
    write_window(48'd5, 48'd4);
    send_branch(48'd4, 1'b1);
    send_branch(48'd5, 1'b0);
    send_branch(48'd0, 1'b1);
    write_window(PC_MAX, PC_MAX);
    send_branch(PC_MAX, 1'b1);
    send_branch(PC_MAX - 1, 1'b0);
  endtask

  // hot branches whose outcome follows the history, some noise and strays
  task automatic test_correlated_loops(int count, logic [tage_pkg::ADDR_W-1:0] base);
    logic [tage_pkg::ADDR_W-1:0] hot [16];
    logic [tage_pkg::ADDR_W-1:0] pc;
    bit tk;
    write_window(base, base + 48'h3FFF);
    gaps_on = 1'b1;
    foreach (hot[k]) hot[k] = base + tage_pkg::ADDR_W'($urandom_range(0, 16'h3FFF));
    for (int n = 0; n < count; n++) begin
      if (n == count - 300) gaps_on = 1'b0;
      case ($urandom_range(0, 19))
        0: pc = tage_pkg::ADDR_W'({$urandom, $urandom});
        1, 2: pc = base + tage_pkg::ADDR_W'($urandom_range(0, 16'h3FFF));
        default: pc = hot[4'($urandom_range(0, 15))];
      endcase
      tk = pc[3] ^ path_hist[0] ^ (pc[4] & path_hist[5]);
      if ($urandom_range(0, 9) == 0) tk = ~tk;
      send_branch(pc, tk);
    end
  endtask

  task automatic test_random_full_range(int count);
    write_window('0, PC_MAX);
    for (int n = 0; n < count; n++)
      send_branch(tage_pkg::ADDR_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    test_reset_window();
    test_full_window_extremes();
    test_empty_window();
    test_random_full_range(300);
    test_correlated_loops(300, 48'h7FFF_FFFF_C000);
    test_correlated_loops(1400, 48'h0000_0040_0000);
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_predictions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
